>>> hw/rtl/mst_pkg.sv
// Shared constants, command and result types for the multi-slot timer table.
package mst_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_RES   = 16;
    localparam int CNT_W     = $clog2(MAX_RES + 1);
    localparam int Q_DEPTH   = 2;
    localparam int QA_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W      = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_STOP_REP = 3'd2,
        OP_SUSPEND  = 3'd3,
        OP_RESUME   = 3'd4,
        OP_TICK     = 3'd5,
        OP_NOP      = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        KIND_STARTED = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_NONE    = 3'd4
    } t_kind;

    typedef struct packed {
        t_op              op;
        logic [31:0]      period;
        logic             repeat_flag;
        logic             slot_ok;
        logic [IDX_W-1:0] slot;
    } t_cmd;

endpackage

>>> hw/rtl/multi_slot_software_timer.sv
// Top level of the multi-slot timer table: front end, command queue, execution unit.
//
// Input channel (i_valid/o_ready) carries one command word: start, stop, stop
// repeat, suspend, resume or tick. Output channel (o_valid/i_ready) returns
// result words; o_last marks the final word of each command.
// Start, stop, stop repeat, suspend and resume give one word; the result passes
// through the command queue and the result register, and the execution unit takes
// one such command per cycle while the receiver accepts results and no tick runs.
// A tick scans the slots one per cycle through the deadline/period memory
// read port, holding at a due slot while an earlier fired word waits for the
// output. Every fired slot gives one word; a quiet tick gives one nothing-fired
// word. Each fired word is held back by one find so the last one can carry
// o_last.
// A two-word command queue sits between front end and execution unit, so input
// words keep being accepted while a result waits for the receiver. When the
// receiver stalls, the scan holds at the next due slot and the queue fills,
// then o_ready drops.
// Reset clears the tick counter and all slot flags; it takes effect at once,
// with no clearing pass.
module multi_slot_software_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_period,
    input  logic        i_repeat_flag,
    input  logic [3:0]  i_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot_id,
    output logic        o_freed,
    output logic        o_last
);

    mst_pkg::t_cmd push_cmd;
    mst_pkg::t_cmd head_cmd;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    mst_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_period      (i_period),
        .i_repeat_flag (i_repeat_flag),
        .i_slot        (i_slot),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    mst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_kind    (o_kind),
        .o_slot_id (o_slot_id),
        .o_freed   (o_freed),
        .o_last    (o_last)
    );

endmodule

>>> hw/rtl/mst_front.sv
// Front end: accepts input words and classifies them into commands.
module mst_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_op,
    input  logic [31:0]   i_period,
    input  logic          i_repeat_flag,
    input  logic [3:0]    i_slot,
    input  logic          i_q_full,
    output logic          o_push,
    output mst_pkg::t_cmd o_cmd
);

    logic slot_ok;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign slot_ok = (32'(i_slot) < mst_pkg::NUM_SLOTS);

    always_comb begin
        o_cmd.period      = i_period;
        o_cmd.repeat_flag = i_repeat_flag;
        o_cmd.slot_ok     = slot_ok;
        o_cmd.slot        = slot_ok ? mst_pkg::IDX_W'(i_slot) : '0;
        unique case (i_op)
            mst_pkg::OP_START:    o_cmd.op = mst_pkg::OP_START;
            mst_pkg::OP_STOP:     o_cmd.op = mst_pkg::OP_STOP;
            mst_pkg::OP_STOP_REP: o_cmd.op = mst_pkg::OP_STOP_REP;
            mst_pkg::OP_SUSPEND:  o_cmd.op = mst_pkg::OP_SUSPEND;
            mst_pkg::OP_RESUME:   o_cmd.op = mst_pkg::OP_RESUME;
            mst_pkg::OP_TICK:     o_cmd.op = mst_pkg::OP_TICK;
            default:              o_cmd.op = mst_pkg::OP_NOP;
        endcase
    end

endmodule

>>> hw/rtl/mst_queue.sv
// Short command queue between the front end and the execution unit.
module mst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mst_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mst_pkg::t_cmd o_cmd
);

    mst_pkg::t_cmd                r_mem [mst_pkg::Q_DEPTH];
    logic [mst_pkg::QA_W-1:0]     r_wp;
    logic [mst_pkg::QA_W-1:0]     r_rp;
    logic [mst_pkg::QC_W-1:0]     r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == mst_pkg::QC_W'(mst_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == mst_pkg::QA_W'(mst_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == mst_pkg::QA_W'(mst_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/mst_back.sv
// Execution unit: slot table, tick scan and result register.
module mst_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mst_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_kind,
    output logic [3:0]    o_slot_id,
    output logic          o_freed,
    output logic          o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    localparam int N  = mst_pkg::NUM_SLOTS;
    localparam int IW = mst_pkg::IDX_W;

    t_state                      r_state;
    logic [31:0]                 r_now;
    logic [N-1:0]                r_used;
    logic [N-1:0]                r_rep;
    logic [N-1:0]                r_susp;
    logic [31:0]                 r_deadline [N];
    logic [31:0]                 r_period   [N];
    logic [31:0]                 r_dl_q;
    logic [31:0]                 r_per_q;
    logic [IW-1:0]               r_idx;
    logic [mst_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_pend_v;
    logic [IW-1:0]               r_pend_id;
    logic                        r_pend_freed;
    logic                        r_out_valid;
    mst_pkg::t_kind              r_kind;
    logic [3:0]                  r_slot_id;
    logic                        r_freed;
    logic                        r_last;

    logic                        out_free;
    logic                        due;
    logic                        can_fire;
    logic                        at_cap;
    logic                        advance;
    logic                        idx_last;
    logic [IW-1:0]               rd_addr;
    logic                        found;
    logic [IW-1:0]               free_idx;
    logic                        hit;
    logic                        take;
    logic                        we_dl;
    logic                        we_per;
    logic [IW-1:0]               wa;
    logic [31:0]                 wdl;

    assign o_valid   = r_out_valid;
    assign o_kind    = r_kind;
    assign o_slot_id = r_slot_id;
    assign o_freed   = r_freed;
    assign o_last    = r_last;

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        out_free = !r_out_valid || i_ready;
        take     = (r_state == S_IDLE) && i_q_valid && out_free;
        o_pop    = take;
        hit      = i_cmd.slot_ok && r_used[i_cmd.slot];
        due      = r_used[r_idx] && !r_susp[r_idx] && (r_dl_q <= r_now);
        can_fire = !r_pend_v || out_free;
        at_cap   = (r_cnt == mst_pkg::CNT_W'(mst_pkg::MAX_RES));
        idx_last = (r_idx == IW'(N - 1));
        advance  = (r_state == S_SCAN) && !at_cap && (!due || can_fire);
        if (advance) begin
            rd_addr = idx_last ? '0 : r_idx + 1'b1;
        end else if (r_state == S_SCAN) begin
            rd_addr = r_idx;
        end else begin
            rd_addr = '0;
        end

        we_dl  = 1'b0;
        we_per = 1'b0;
        wa     = r_idx;
        wdl    = r_now + r_per_q;
        if (take && i_cmd.op == mst_pkg::OP_START && found) begin
            we_dl  = 1'b1;
            we_per = 1'b1;
            wa     = free_idx;
            wdl    = r_now + i_cmd.period;
        end else if (take && i_cmd.op == mst_pkg::OP_RESUME && hit) begin
            we_dl = 1'b1;
            wa    = i_cmd.slot;
            wdl   = '0;
        end else if (advance && due && r_rep[r_idx]) begin
            we_dl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_dl) begin
            r_deadline[wa] <= wdl;
        end
        if (we_per) begin
            r_period[wa] <= i_cmd.period;
        end
        r_dl_q  <= r_deadline[rd_addr];
        r_per_q <= r_period[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_used      <= '0;
            r_rep       <= '0;
            r_susp      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_slot_id <= '0;
                        r_freed   <= 1'b0;
                        r_last    <= 1'b1;
                        r_kind    <= mst_pkg::KIND_DONE;
                        unique case (i_cmd.op)
                            mst_pkg::OP_TICK: begin
                                r_now    <= r_now + 1'b1;
                                r_idx    <= '0;
                                r_cnt    <= '0;
                                r_pend_v <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                            mst_pkg::OP_START: begin
                                r_out_valid <= 1'b1;
                                if (found) begin
                                    r_used[free_idx] <= 1'b1;
                                    r_rep[free_idx]  <= i_cmd.repeat_flag;
                                    r_susp[free_idx] <= 1'b0;
                                    r_kind           <= mst_pkg::KIND_STARTED;
                                    r_slot_id        <= 4'(free_idx);
                                end else begin
                                    r_kind <= mst_pkg::KIND_FULL;
                                end
                            end
                            mst_pkg::OP_STOP: begin
                                r_out_valid <= 1'b1;
                                if (hit) begin
                                    r_used[i_cmd.slot] <= 1'b0;
                                end
                            end
                            mst_pkg::OP_STOP_REP: begin
                                r_out_valid <= 1'b1;
                                if (hit) begin
                                    r_rep[i_cmd.slot] <= 1'b0;
                                end
                            end
                            mst_pkg::OP_SUSPEND: begin
                                r_out_valid <= 1'b1;
                                if (hit) begin
                                    r_susp[i_cmd.slot] <= 1'b1;
                                end
                            end
                            mst_pkg::OP_RESUME: begin
                                r_out_valid <= 1'b1;
                                if (hit) begin
                                    r_susp[i_cmd.slot] <= 1'b0;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (at_cap) begin
                        r_state <= S_FIN;
                    end else if (advance) begin
                        if (due) begin
                            if (r_pend_v) begin
                                r_out_valid <= 1'b1;
                                r_kind      <= mst_pkg::KIND_FIRED;
                                r_slot_id   <= 4'(r_pend_id);
                                r_freed     <= r_pend_freed;
                                r_last      <= 1'b0;
                            end
                            r_pend_v     <= 1'b1;
                            r_pend_id    <= r_idx;
                            r_pend_freed <= !r_rep[r_idx];
                            if (!r_rep[r_idx]) begin
                                r_used[r_idx] <= 1'b0;
                            end
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (idx_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_last      <= 1'b1;
                        if (r_pend_v) begin
                            r_kind    <= mst_pkg::KIND_FIRED;
                            r_slot_id <= 4'(r_pend_id);
                            r_freed   <= r_pend_freed;
                        end else begin
                            r_kind    <= mst_pkg::KIND_NONE;
                            r_slot_id <= '0;
                            r_freed   <= 1'b0;
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
